// File: rtl/sorted_deadline_timer_manager_top_macros.svh
// Assertion macros shared by the timer manager checker.
`ifndef SORTED_DEADLINE_TIMER_MANAGER_TOP_MACROS_SVH
`define SORTED_DEADLINE_TIMER_MANAGER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SDTM_ASSERT_HOLD(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SDTM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sdtm_pkg.sv
// Shared types, codes and constants of the sorted deadline timer manager.
package sdtm_pkg;

	// Default pool size and widest index (pool of 64 plus the sentinel).
	localparam int TIMERS_DEF = 16;
	localparam int IDX_MAX_W = 7;

	localparam logic [31:0] END_DEADLINE = 32'hffff_ffff;

	// Action codes.
	localparam logic [2:0] ACT_TICK = 3'd0;
	localparam logic [2:0] ACT_ALLOC = 3'd1;
	localparam logic [2:0] ACT_FREE = 3'd2;
	localparam logic [2:0] ACT_INIT = 3'd3;
	localparam logic [2:0] ACT_SET = 3'd4;
	localparam logic [2:0] ACT_CANCEL = 3'd5;
	localparam logic [2:0] ACT_CANCEL_ALL = 3'd6;

	// Result kinds.
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_DELIVER = 2'd1;
	localparam logic [1:0] KIND_TASK = 2'd2;
	localparam logic [1:0] KIND_ALLOC = 2'd3;

	// Entry states.
	localparam logic [1:0] ES_UNUSED = 2'd0;
	localparam logic [1:0] ES_ALLOC = 2'd1;
	localparam logic [1:0] ES_RUNNING = 2'd2;

	// Register address of the task timer register.
	localparam logic [2:0] REG_TASK_TIMER = 3'd0;
	localparam logic [4:0] TASK_TIMER_RST = 5'd16;

	// Request from the sequencer to the entry memories.
	typedef struct packed {
		logic [IDX_MAX_W-1:0] raddr;
		logic ld_we;
		logic [IDX_MAX_W-1:0] ld_waddr;
		logic [31:0] ld_wdeadline;
		logic [IDX_MAX_W-1:0] ld_wlink;
		logic dp_we;
		logic [IDX_MAX_W-1:0] dp_waddr;
		logic [3:0] dp_wdest;
		logic [31:0] dp_wdata;
	} mem_req_t;

	// Registered read data of both memories at the same address.
	typedef struct packed {
		logic [31:0] deadline;
		logic [IDX_MAX_W-1:0] link;
		logic [3:0] dest;
		logic [31:0] data;
	} mem_rsp_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0] kind;
		logic ok;
		logic [3:0] entry;
		logic [3:0] dest;
		logic [31:0] data;
		logic last;
	} result_t;

	function automatic result_t mk_res(input logic [1:0] kind, input logic ok,
		input logic [3:0] entry, input logic [3:0] dest, input logic [31:0] data,
		input logic last);
		result_t r;
		r.kind = kind;
		r.ok = ok;
		r.entry = entry;
		r.dest = dest;
		r.data = data;
		r.last = last;
		return r;
	endfunction

endpackage

// File: rtl/sorted_deadline_timer_manager_top.sv
// Top level of the sorted deadline timer manager: register port and wiring.
//
// Channel   Handshake                        Contents
// command   start, accepted when busy low    action, timer_id, delay, dest_id, payload,
//                                            auto_cancel
// result    valid, one cycle, always taken   kind, ok, entry, dest_out, data_out, last
// register  APB write/read, pready tied 1    task switch timer index at byte address 0
//
// Init, unknown actions, refused commands and ticks with nothing due answer the cycle
// after acceptance. A tick expires due timers from the head, one result each, then a
// status. Alloc and cancel all scan one entry per cycle (up to TIMERS, cancel all plus
// an unlink walk per match). Set time, cancel and free walk the list with one memory
// read per hop. No clearing pass follows reset; results cannot be stalled.
module sorted_deadline_timer_manager_top #(
	parameter int TIMERS = sdtm_pkg::TIMERS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [2:0] action,
	input logic [3:0] timer_id,
	input logic [31:0] delay,
	input logic [3:0] dest_id,
	input logic [31:0] payload,
	input logic auto_cancel,
	output logic valid,
	output logic [1:0] kind,
	output logic ok,
	output logic [3:0] entry,
	output logic [3:0] dest_out,
	output logic [31:0] data_out,
	output logic last,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import sdtm_pkg::*;

	logic [4:0] task_q;
	result_t res;
	mem_req_t mem_req;
	mem_rsp_t mem_rsp;

	// Task timer register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_q <= TASK_TIMER_RST;
		end else if (psel && penable && pwrite && paddr == REG_TASK_TIMER) begin
			task_q <= pwdata[4:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_TASK_TIMER) ? {27'd0, task_q} : 32'd0;

	sdtm_ctrl #(.TIMERS(TIMERS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.action(action),
		.timer_id(timer_id),
		.delay(delay),
		.dest_id(dest_id),
		.payload(payload),
		.auto_cancel(auto_cancel),
		.task_id(task_q),
		.busy(busy),
		.res_valid(valid),
		.res(res),
		.mem_req(mem_req),
		.mem_rsp(mem_rsp)
	);

	sdtm_mem #(.TIMERS(TIMERS)) u_mem (
		.clk(clk),
		.req(mem_req),
		.rsp(mem_rsp)
	);

	assign kind = res.kind;
	assign ok = res.ok;
	assign entry = res.entry;
	assign dest_out = res.dest;
	assign data_out = res.data;
	assign last = res.last;

endmodule

// File: rtl/sdtm_mem.sv
// Entry memories: deadline with link, and destination with payload.
module sdtm_mem #(
	parameter int TIMERS = sdtm_pkg::TIMERS_DEF
) (
	input logic clk,
	input sdtm_pkg::mem_req_t req,
	output sdtm_pkg::mem_rsp_t rsp
);
	import sdtm_pkg::*;

	localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int IW = $clog2(TIMERS + 1);

	logic [32+IW-1:0] ld_mem [TIMERS];
	logic [35:0] dp_mem [TIMERS];
	logic [32+IW-1:0] ld_rd_q;
	logic [35:0] dp_rd_q;

	// Deadline and link memory.
	always_ff @(posedge clk) begin
		if (req.ld_we) begin
			ld_mem[AW'(req.ld_waddr)] <= {req.ld_wdeadline, IW'(req.ld_wlink)};
		end
		ld_rd_q <= ld_mem[AW'(req.raddr)];
	end

	// Destination and payload memory.
	always_ff @(posedge clk) begin
		if (req.dp_we) begin
			dp_mem[AW'(req.dp_waddr)] <= {req.dp_wdest, req.dp_wdata};
		end
		dp_rd_q <= dp_mem[AW'(req.raddr)];
	end

	assign rsp.deadline = ld_rd_q[32+IW-1:IW];
	assign rsp.link = IDX_MAX_W'(ld_rd_q[IW-1:0]);
	assign rsp.dest = dp_rd_q[35:32];
	assign rsp.data = dp_rd_q[31:0];

endmodule

// File: rtl/sdtm_ctrl.sv
// Sequencer that walks the sorted timer list held in the entry memories.
module sdtm_ctrl #(
	parameter int TIMERS = sdtm_pkg::TIMERS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [2:0] action,
	input logic [3:0] timer_id,
	input logic [31:0] delay,
	input logic [3:0] dest_id,
	input logic [31:0] payload,
	input logic auto_cancel,
	input logic [4:0] task_id,
	output logic busy,
	output logic res_valid,
	output sdtm_pkg::result_t res,
	output sdtm_pkg::mem_req_t mem_req,
	input sdtm_pkg::mem_rsp_t mem_rsp
);
	import sdtm_pkg::*;

	localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int IW = $clog2(TIMERS + 1);
	localparam logic [IW-1:0] SENT = IW'(TIMERS);
	localparam logic [AW-1:0] LAST_IDX = AW'(TIMERS - 1);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0_0000_0000_0001,
		S_ALLOC = 13'b0_0000_0000_0010,
		S_TICK = 13'b0_0000_0000_0100,
		S_SET_WALK = 13'b0_0000_0000_1000,
		S_SET_INS = 13'b0_0000_0001_0000,
		S_SET_LINK = 13'b0_0000_0010_0000,
		S_UL_RDT = 13'b0_0000_0100_0000,
		S_UL_HEAD = 13'b0_0000_1000_0000,
		S_UL_WALK = 13'b0_0001_0000_0000,
		S_UL_END = 13'b0_0010_0000_0000,
		S_CA_SCAN = 13'b0_0100_0000_0000,
		S_CA_CHK = 13'b0_1000_0000_0000,
		S_DONE = 13'b1_0000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] op_q, op_d;
	logic [AW-1:0] tid_q, tid_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [3:0] dest_q, dest_d;
	logic [31:0] dl_q, dl_d;
	logic [31:0] prev_dl_q, prev_dl_d;
	logic [31:0] count_q, count_d;
	logic [31:0] nd_q, nd_d;
	logic [IW-1:0] head_q, head_d;
	logic [IW-1:0] cur_q, cur_d;
	logic [IW-1:0] prev_q, prev_d;
	logic [IW-1:0] lt_q, lt_d;
	logic ok_q, ok_d;
	logic [1:0] ustate_q [TIMERS];
	logic canc_q [TIMERS];
	logic st_we;
	logic [AW-1:0] st_idx;
	logic [1:0] st_val;
	logic canc_we;
	logic [AW-1:0] canc_idx;
	logic canc_val;
	logic out_v_d;
	result_t out_d;
	logic res_valid_q;
	result_t res_q;
	logic [31:0] count_inc;
	logic id_ok;
	logic [AW-1:0] id_idx;
	logic [IW-1:0] rd_link;
	logic [AW-1:0] head_idx;

	assign count_inc = count_q + 32'd1;
	assign id_ok = (int'(timer_id) < TIMERS);
	assign id_idx = AW'(timer_id);
	assign rd_link = IW'(mem_rsp.link);
	assign head_idx = AW'(head_q);

	// Next-state logic of the list sequencer.
	always_comb begin
		state_d = state_q;
		op_d = op_q;
		tid_d = tid_q;
		idx_d = idx_q;
		dest_d = dest_q;
		dl_d = dl_q;
		prev_dl_d = prev_dl_q;
		count_d = count_q;
		nd_d = nd_q;
		head_d = head_q;
		cur_d = cur_q;
		prev_d = prev_q;
		lt_d = lt_q;
		ok_d = ok_q;
		st_we = 1'b0;
		st_idx = tid_q;
		st_val = ES_UNUSED;
		canc_we = 1'b0;
		canc_idx = tid_q;
		canc_val = 1'b0;
		out_v_d = 1'b0;
		out_d = '0;
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_d = action;
					tid_d = id_idx;
					dest_d = dest_id;
					out_d = mk_res(KIND_STATUS, 1'b0, 4'd0, 4'd0, 32'd0, 1'b1);
					case (action)
						ACT_TICK: begin
							count_d = count_inc;
							if (head_q < SENT && nd_q <= count_inc) begin
								mem_req.raddr = IDX_MAX_W'(head_q);
								state_d = S_TICK;
							end else begin
								out_v_d = 1'b1;
								out_d.ok = 1'b1;
							end
						end
						ACT_ALLOC: begin
							idx_d = '0;
							state_d = S_ALLOC;
						end
						ACT_FREE: begin
							if (!id_ok) begin
								out_v_d = 1'b1;
							end else if (ustate_q[id_idx] == ES_RUNNING) begin
								mem_req.raddr = IDX_MAX_W'(id_idx);
								state_d = S_UL_RDT;
							end else begin
								st_we = 1'b1;
								st_idx = id_idx;
								st_val = ES_UNUSED;
								out_v_d = 1'b1;
								out_d.ok = 1'b1;
							end
						end
						ACT_INIT: begin
							out_v_d = 1'b1;
							if (id_ok) begin
								mem_req.dp_we = 1'b1;
								mem_req.dp_waddr = IDX_MAX_W'(id_idx);
								mem_req.dp_wdest = dest_id;
								mem_req.dp_wdata = payload;
								canc_we = 1'b1;
								canc_idx = id_idx;
								canc_val = auto_cancel;
								out_d.ok = 1'b1;
							end
						end
						ACT_SET: begin
							if (id_ok && ustate_q[id_idx] == ES_ALLOC) begin
								dl_d = delay + count_q;
								prev_d = SENT;
								cur_d = head_q;
								st_we = 1'b1;
								st_idx = id_idx;
								st_val = ES_RUNNING;
								if (head_q >= SENT) begin
									state_d = S_SET_INS;
								end else begin
									mem_req.raddr = IDX_MAX_W'(head_q);
									state_d = S_SET_WALK;
								end
							end else begin
								out_v_d = 1'b1;
							end
						end
						ACT_CANCEL: begin
							if (id_ok && ustate_q[id_idx] == ES_RUNNING) begin
								mem_req.raddr = IDX_MAX_W'(id_idx);
								state_d = S_UL_RDT;
							end else begin
								out_v_d = 1'b1;
							end
						end
						ACT_CANCEL_ALL: begin
							idx_d = '0;
							state_d = S_CA_SCAN;
						end
						default: begin
							out_v_d = 1'b1;
						end
					endcase
				end
			end
			// Scan one entry per cycle for an unused one.
			S_ALLOC: begin
				if (ustate_q[idx_q] == ES_UNUSED) begin
					st_we = 1'b1;
					st_idx = idx_q;
					st_val = ES_ALLOC;
					canc_we = 1'b1;
					canc_idx = idx_q;
					canc_val = 1'b0;
					out_v_d = 1'b1;
					out_d = mk_res(KIND_ALLOC, 1'b1, 4'(idx_q), 4'd0, 32'd0, 1'b1);
					state_d = S_IDLE;
				end else if (idx_q == LAST_IDX) begin
					out_v_d = 1'b1;
					out_d = mk_res(KIND_ALLOC, 1'b0, 4'd0, 4'd0, 32'd0, 1'b1);
					state_d = S_IDLE;
				end else begin
					idx_d = idx_q + AW'(1);
				end
			end
			// Read data holds the head entry; expire it if due.
			S_TICK: begin
				if (mem_rsp.deadline <= count_q) begin
					st_we = 1'b1;
					st_idx = head_idx;
					st_val = ES_ALLOC;
					head_d = rd_link;
					out_v_d = 1'b1;
					if (IDX_MAX_W'(head_q) == IDX_MAX_W'(task_id)) begin
						out_d = mk_res(KIND_TASK, 1'b0, 4'(head_q), 4'd0, 32'd0, 1'b0);
					end else begin
						out_d = mk_res(KIND_DELIVER, 1'b0, 4'(head_q), mem_rsp.dest,
							mem_rsp.data, 1'b0);
					end
					if (rd_link >= SENT) begin
						nd_d = END_DEADLINE;
						ok_d = 1'b1;
						state_d = S_DONE;
					end else begin
						mem_req.raddr = IDX_MAX_W'(rd_link);
					end
				end else begin
					nd_d = mem_rsp.deadline;
					out_v_d = 1'b1;
					out_d = mk_res(KIND_STATUS, 1'b1, 4'd0, 4'd0, 32'd0, 1'b1);
					state_d = S_IDLE;
				end
			end
			// Walk to the first entry whose deadline is not below the new one.
			S_SET_WALK: begin
				if (dl_q <= mem_rsp.deadline) begin
					state_d = S_SET_INS;
				end else begin
					prev_d = cur_q;
					prev_dl_d = mem_rsp.deadline;
					cur_d = rd_link;
					if (rd_link >= SENT) begin
						state_d = S_SET_INS;
					end else begin
						mem_req.raddr = IDX_MAX_W'(rd_link);
					end
				end
			end
			S_SET_INS: begin
				mem_req.ld_we = 1'b1;
				mem_req.ld_waddr = IDX_MAX_W'(tid_q);
				mem_req.ld_wdeadline = dl_q;
				mem_req.ld_wlink = IDX_MAX_W'(cur_q);
				ok_d = 1'b1;
				if (prev_q >= SENT) begin
					head_d = IW'(tid_q);
					nd_d = dl_q;
					state_d = S_DONE;
				end else begin
					state_d = S_SET_LINK;
				end
			end
			S_SET_LINK: begin
				mem_req.ld_we = 1'b1;
				mem_req.ld_waddr = IDX_MAX_W'(prev_q);
				mem_req.ld_wdeadline = prev_dl_q;
				mem_req.ld_wlink = IDX_MAX_W'(tid_q);
				state_d = S_DONE;
			end
			// Read data holds the entry to unlink.
			S_UL_RDT: begin
				lt_d = rd_link;
				if (head_q == IW'(tid_q)) begin
					head_d = rd_link;
					if (rd_link >= SENT) begin
						nd_d = END_DEADLINE;
						state_d = S_UL_END;
					end else begin
						mem_req.raddr = IDX_MAX_W'(rd_link);
						state_d = S_UL_HEAD;
					end
				end else begin
					cur_d = head_q;
					mem_req.raddr = IDX_MAX_W'(head_q);
					state_d = S_UL_WALK;
				end
			end
			S_UL_HEAD: begin
				nd_d = mem_rsp.deadline;
				state_d = S_UL_END;
			end
			// Find the predecessor and bypass the entry.
			S_UL_WALK: begin
				if (rd_link == IW'(tid_q)) begin
					mem_req.ld_we = 1'b1;
					mem_req.ld_waddr = IDX_MAX_W'(cur_q);
					mem_req.ld_wdeadline = mem_rsp.deadline;
					mem_req.ld_wlink = IDX_MAX_W'(lt_q);
					state_d = S_UL_END;
				end else begin
					cur_d = rd_link;
					mem_req.raddr = IDX_MAX_W'(rd_link);
				end
			end
			S_UL_END: begin
				st_we = 1'b1;
				st_idx = tid_q;
				st_val = (op_q == ACT_CANCEL) ? ES_ALLOC : ES_UNUSED;
				if (op_q == ACT_CANCEL_ALL && idx_q != LAST_IDX) begin
					idx_d = idx_q + AW'(1);
					state_d = S_CA_SCAN;
				end else begin
					out_v_d = 1'b1;
					out_d = mk_res(KIND_STATUS, 1'b1, 4'd0, 4'd0, 32'd0, 1'b1);
					state_d = S_IDLE;
				end
			end
			// Cancel all: pick used, cancellable entries one per cycle, pausing to check each pick.
			S_CA_SCAN: begin
				if (ustate_q[idx_q] != ES_UNUSED && canc_q[idx_q]) begin
					mem_req.raddr = IDX_MAX_W'(idx_q);
					state_d = S_CA_CHK;
				end else if (idx_q == LAST_IDX) begin
					out_v_d = 1'b1;
					out_d = mk_res(KIND_STATUS, 1'b1, 4'd0, 4'd0, 32'd0, 1'b1);
					state_d = S_IDLE;
				end else begin
					idx_d = idx_q + AW'(1);
				end
			end
			S_CA_CHK: begin
				if (mem_rsp.dest == dest_q && ustate_q[idx_q] == ES_RUNNING) begin
					tid_d = idx_q;
					mem_req.raddr = IDX_MAX_W'(idx_q);
					state_d = S_UL_RDT;
				end else begin
					if (mem_rsp.dest == dest_q) begin
						st_we = 1'b1;
						st_idx = idx_q;
						st_val = ES_UNUSED;
					end
					if (idx_q == LAST_IDX) begin
						out_v_d = 1'b1;
						out_d = mk_res(KIND_STATUS, 1'b1, 4'd0, 4'd0, 32'd0, 1'b1);
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + AW'(1);
						state_d = S_CA_SCAN;
					end
				end
			end
			S_DONE: begin
				out_v_d = 1'b1;
				out_d = mk_res(KIND_STATUS, ok_q, 4'd0, 4'd0, 32'd0, 1'b1);
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			nd_q <= END_DEADLINE;
			head_q <= SENT;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			nd_q <= nd_d;
			head_q <= head_d;
			res_valid_q <= out_v_d;
		end
	end

	// Entry state and cancellable marks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMERS; i++) begin
				ustate_q[i] <= ES_UNUSED;
				canc_q[i] <= 1'b0;
			end
		end else begin
			if (st_we) begin
				ustate_q[st_idx] <= st_val;
			end
			if (canc_we) begin
				canc_q[canc_idx] <= canc_val;
			end
		end
	end

	// Working registers of the current transaction and the result.
	always_ff @(posedge clk) begin
		op_q <= op_d;
		tid_q <= tid_d;
		idx_q <= idx_d;
		dest_q <= dest_d;
		dl_q <= dl_d;
		prev_dl_q <= prev_dl_d;
		cur_q <= cur_d;
		prev_q <= prev_d;
		lt_q <= lt_d;
		ok_q <= ok_d;
		res_q <= out_d;
	end

	assign busy = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

// File: rtl/sdtm_checker.sv
// Port-level checker of the timer manager and its bind to the top level.
`include "sorted_deadline_timer_manager_top_macros.svh"

module sdtm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic valid,
	input logic [1:0] kind,
	input logic [3:0] dest_out,
	input logic [31:0] data_out,
	input logic last
);
	import sdtm_pkg::*;

	// A result closes its transaction exactly when the block has gone idle.
	`SDTM_ASSERT_HOLD(a_last_idle, valid, last == !busy, "last does not match busy")
	// An accepted command either keeps the block busy or answers at once.
	`SDTM_ASSERT_NEXT(a_accept, start && !busy, busy || (valid && last), "no answer")
	// Nothing appears while idle without a new command.
	`SDTM_ASSERT_NEXT(a_quiet, !busy && !start, !valid, "spurious result")
	// Only deliveries carry destination and data.
	`SDTM_ASSERT_HOLD(a_clean, valid && kind != KIND_DELIVER,
		dest_out == 4'd0 && data_out == 32'd0, "stray delivery fields")

endmodule

bind sorted_deadline_timer_manager_top sdtm_checker u_sdtm_checker (.*);

// File: tb/sv/tb_sorted_deadline_timer_manager_top.sv
// Self-checking testbench for the sorted deadline timer manager top level.
module tb_sorted_deadline_timer_manager_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sdtm_pkg::*;

	localparam int POOL = 16;
	localparam logic [2:0] ACT_UNKNOWN = 3'd7;
	localparam int SETTLE_CYCLES = 80;

	// Timer pool mirror and queue of results still owed by the block.
	class deadline_scoreboard;
		result_t owed[$];
		int fails;
		int n_deliver;
		int n_task;
		int n_cmd;
		logic [4:0] switch_timer;
		logic [31:0] now;
		logic [4:0] head;
		logic [1:0] st[POOL];
		logic [31:0] dl[POOL];
		logic [4:0] lk[POOL];
		logic [3:0] dst[POOL];
		logic [31:0] pay[POOL];
		logic canc[POOL];

		function new();
			fails = 0;
			n_deliver = 0;
			n_task = 0;
			n_cmd = 0;
			switch_timer = TASK_TIMER_RST;
			now = '0;
			head = 5'(POOL);
			for (int i = 0; i < POOL; i++) begin
				st[i] = ES_UNUSED;
				dl[i] = '0;
				lk[i] = '0;
				dst[i] = '0;
				pay[i] = '0;
				canc[i] = 1'b0;
			end
		endfunction

		function void owe(logic [1:0] k, logic o, logic [3:0] e, logic [3:0] d,
			logic [31:0] v, logic l);
			result_t r;
			r.kind = k;
			r.ok = o;
			r.entry = e;
			r.dest = d;
			r.data = v;
			r.last = l;
			owed.push_back(r);
		endfunction

		// Take a running timer out of the sorted list.
		function bit detach(int t);
			int cur;
			if (st[t] != ES_RUNNING) return 0;
			if (head == t) begin
				head = lk[t];
			end else begin
				cur = head;
				for (int n = 0; n < POOL && cur < POOL; n++) begin
					if (lk[cur] == t) begin
						lk[cur] = lk[t];
						break;
					end
					cur = lk[cur];
				end
			end
			st[t] = ES_ALLOC;
			return 1;
		endfunction

		// Insert ahead of any timer with an equal deadline.
		function void insert_sorted(int t);
			int prev;
			int cur;
			prev = POOL;
			cur = head;
			while (cur < POOL && dl[t] > dl[cur]) begin
				prev = cur;
				cur = lk[cur];
			end
			lk[t] = 5'(cur);
			if (prev == POOL) head = 5'(t);
			else lk[prev] = 5'(t);
		endfunction

		// Work out every result that one accepted command causes.
		function void note_command(logic [2:0] act, logic [3:0] id, logic [31:0] dly,
			logic [3:0] dest, logic [31:0] data, logic ac);
			logic good;
			int t;
			good = 1'b0;
			n_cmd++;
			case (act)
				ACT_TICK: begin
					now = now + 32'd1;
					while (head < POOL && dl[head] <= now) begin
						t = head;
						st[t] = ES_ALLOC;
						head = lk[t];
						if (t == switch_timer) begin
							owe(KIND_TASK, 1'b0, 4'(t), '0, '0, 1'b0);
							n_task++;
						end else begin
							owe(KIND_DELIVER, 1'b0, 4'(t), dst[t], pay[t], 1'b0);
							n_deliver++;
						end
					end
					good = 1'b1;
				end
				ACT_ALLOC: begin
					for (int i = 0; i < POOL; i++) begin
						if (st[i] == ES_UNUSED) begin
							st[i] = ES_ALLOC;
							canc[i] = 1'b0;
							owe(KIND_ALLOC, 1'b1, 4'(i), '0, '0, 1'b1);
							return;
						end
					end
					owe(KIND_ALLOC, 1'b0, '0, '0, '0, 1'b1);
					return;
				end
				ACT_FREE: begin
					void'(detach(id));
					st[id] = ES_UNUSED;
					good = 1'b1;
				end
				ACT_INIT: begin
					dst[id] = dest;
					pay[id] = data;
					canc[id] = ac;
					good = 1'b1;
				end
				ACT_SET: begin
					if (st[id] == ES_ALLOC) begin
						dl[id] = dly + now;
						st[id] = ES_RUNNING;
						insert_sorted(id);
						good = 1'b1;
					end
				end
				ACT_CANCEL: good = detach(id);
				ACT_CANCEL_ALL: begin
					for (int i = 0; i < POOL; i++) begin
						if (st[i] != ES_UNUSED && canc[i] && dst[i] == dest) begin
							void'(detach(i));
							st[i] = ES_UNUSED;
						end
					end
					good = 1'b1;
				end
				default: good = 1'b0;
			endcase
			owe(KIND_STATUS, good, '0, '0, '0, 1'b1);
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $realtime, what);
			fails++;
		endtask

		// Compare one result transaction with the oldest one owed.
		task check_result(result_t got);
			result_t want;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = owed.pop_front();
			if (got.kind !== want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
			if (got.ok !== want.ok) report($sformatf("ok %0d want %0d", got.ok, want.ok));
			if (got.entry !== want.entry)
				report($sformatf("entry %0d want %0d", got.entry, want.entry));
			if (got.dest !== want.dest)
				report($sformatf("dest_out %0d want %0d", got.dest, want.dest));
			if (got.data !== want.data)
				report($sformatf("data_out %h want %h", got.data, want.data));
			if (got.last !== want.last) report($sformatf("last %0d want %0d", got.last, want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] action;
	logic [3:0] timer_id;
	logic [31:0] delay;
	logic [3:0] dest_id;
	logic [31:0] payload;
	logic auto_cancel;
	logic valid;
	logic [1:0] kind;
	logic ok;
	logic [3:0] entry;
	logic [3:0] dest_out;
	logic [31:0] data_out;
	logic last;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	deadline_scoreboard sb;
	bit inited[POOL];
	int item_no;

	sorted_deadline_timer_manager_top DUT (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Every result is taken at the edge that ends its cycle.
	always @(posedge clk) begin
		result_t r;
		if (arst_n && valid) begin
			r.kind = kind;
			r.ok = ok;
			r.entry = entry;
			r.dest = dest_out;
			r.data = data_out;
			r.last = last;
			sb.check_result(r);
		end
	end

	// Drive one command and hold it until the block takes it.
	task send_command(logic [2:0] act, logic [3:0] id, logic [31:0] dly, logic [3:0] dest,
		logic [31:0] data, logic ac);
		@(negedge clk);
		start = 1'b1;
		action = act;
		timer_id = id;
		delay = dly;
		dest_id = dest;
		payload = data;
		auto_cancel = ac;
		do @(posedge clk); while (busy);
		sb.note_command(act, id, dly, dest, data, ac);
		if (act == ACT_INIT) inited[id] = 1'b1;
		item_no++;
	endtask

	task idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
		end
	endtask

	// Let every owed result arrive, then let a last scan finish.
	task drain();
		idle_cycles(1);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write followed by a read back.
	task write_switch_sel(logic [4:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = REG_TASK_TIMER;
		pwdata = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		sb.switch_timer = value;
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata[4:0] !== value) sb.report($sformatf("task switch timer reads %h", prdata));
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Pick an entry, preferring ones in the wanted state.
	function logic [3:0] pick_id(logic [1:0] want);
		logic [3:0] id;
		id = 4'($urandom_range(0, POOL - 1));
		for (int n = 0; n < 6; n++) begin
			if (sb.st[id] == want && (want != ES_ALLOC || inited[id])) return id;
			id = 4'($urandom_range(0, POOL - 1));
		end
		return id;
	endfunction

	// One random command, mostly a well-formed timer operation.
	task random_command();
		int w;
		logic [3:0] id;
		logic [31:0] dly;
		w = $urandom_range(0, 99);
		id = 4'($urandom_range(0, POOL - 1));
		case ($urandom_range(0, 9))
			0: dly = $urandom;
			1: dly = 32'hffff_ffff - $urandom_range(0, 3);
			default: dly = $urandom_range(0, 8);
		endcase
		if (w < 26) begin
			send_command(ACT_TICK, 4'($urandom), $urandom, 4'($urandom), $urandom,
				1'($urandom));
		end else if (w < 38) begin
			send_command(ACT_ALLOC, 4'($urandom), $urandom, 4'($urandom), $urandom,
				1'($urandom));
		end else if (w < 46) begin
			send_command(ACT_FREE, pick_id(ES_ALLOC), $urandom, 4'($urandom), $urandom,
				1'($urandom));
		end else if (w < 60) begin
			send_command(ACT_INIT, id, $urandom, ($urandom_range(0, 4) == 0) ?
				4'($urandom) : 4'($urandom_range(0, 3)), $urandom, 1'($urandom));
		end else if (w < 82) begin
			id = pick_id(ES_ALLOC);
			if (inited[id]) send_command(ACT_SET, id, dly, 4'($urandom), $urandom,
				1'($urandom));
			else send_command(ACT_INIT, id, $urandom, 4'($urandom_range(0, 3)), $urandom,
				1'($urandom));
		end else if (w < 90) begin
			send_command(ACT_CANCEL, pick_id(ES_RUNNING), $urandom, 4'($urandom), $urandom,
				1'($urandom));
		end else if (w < 97) begin
			send_command(ACT_CANCEL_ALL, id, $urandom, 4'($urandom_range(0, 3)), $urandom,
				1'($urandom));
		end else begin
			send_command(ACT_UNKNOWN, id, $urandom, 4'($urandom), $urandom, 1'($urandom));
		end
	endtask

	// Run limit far above the slowest legal run.
	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [4:0] task_setting[5];
		task_setting = '{5'd0, 5'd15, 5'd31, 5'd7, 5'd16};
		sb = new();
		item_no = 0;
		foreach (inited[i]) inited[i] = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_TICK;
		timer_id = '0;
		delay = '0;
		dest_id = '0;
		payload = '0;
		auto_cancel = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: fill the pool, then the extremes and each refusal path.
		for (int i = 0; i <= POOL; i++) send_command(ACT_ALLOC, '0, '0, '0, '0, 1'b0);
		send_command(ACT_INIT, 4'd0, '0, 4'd0, 32'h0, 1'b0);
		send_command(ACT_INIT, 4'd15, '1, 4'd15, 32'hffff_ffff, 1'b1);
		send_command(ACT_SET, 4'd0, 32'd0, '0, '0, 1'b0);
		send_command(ACT_SET, 4'd15, 32'hffff_ffff, '0, '0, 1'b0);
		send_command(ACT_SET, 4'd15, 32'd1, '0, '0, 1'b0);
		send_command(ACT_CANCEL, 4'd3, '0, '0, '0, 1'b0);
		send_command(ACT_UNKNOWN, 4'd9, '1, '1, '1, 1'b1);
		send_command(ACT_TICK, '0, '0, '0, '0, 1'b0);
		send_command(ACT_CANCEL_ALL, '0, '0, 4'd15, '0, 1'b0);
		send_command(ACT_FREE, 4'd0, '0, '0, '0, 1'b0);
		drain();

		// Random phases, one task switch timer setting each.
		foreach (task_setting[p]) begin
			write_switch_sel(task_setting[p]);
			for (int n = 0; n < 50; n++) begin
				random_command();
				if (!(p == 2) && $urandom_range(0, 99) < 24) idle_cycles($urandom_range(1, 5));
			end
			drain();
		end

		$display("Covered %0d commands: %0d deliveries and %0d task switch requests.",
			item_no, sb.n_deliver, sb.n_task);
		$display("Tick count reached %0d across five task switch timer settings.", sb.now);
		if (sb.fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
